FILE: rtl/core/anagram_window_matcher_defines.svh
// Assertion macros shared by the anagram window matcher RTL.
`ifndef ANAGRAM_WINDOW_MATCHER_DEFINES_SVH
`define ANAGRAM_WINDOW_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AWM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("anagram_window_matcher: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("anagram_window_matcher: next-cycle check failed");

`else

`define AWM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define AWM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/awm_pkg.sv
// Shared constants, codes and types of the anagram window matcher.
`default_nettype none

package awm_pkg;

   // Pattern capacity, also the depth of the text delay line.
   localparam int MAX_PATTERN = 256;
   // Number of letters in the alphabet.
   localparam int ALPHABET    = 26;

   // Width of a letter index on the request channel.
   localparam int SYM_W = 5;
   // Counts and lengths must hold the full capacity itself.
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   // Delay line address width.
   localparam int POS_W = $clog2(MAX_PATTERN);

   // Request queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths; the data fields are padded to whole bytes.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;

   // Request kinds as carried on req_tuser.
   typedef enum logic [REQ_USER_W-1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_PATTERN = 2'd1,
      KIND_TEXT    = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   // One classified request waiting in the queue.
   typedef struct packed {
      kind_type         kind;
      logic [SYM_W-1:0] sym;
   } entry_type;

   // Control handed from the sequencing stage to the letter cells.
   typedef struct packed {
      kind_type         kind;
      logic [SYM_W-1:0] sym;
      logic             add;           // pattern letter is counted
      logic             rem;           // oldest window letter leaves
      logic             full;          // window holds a whole pattern length
      logic             always_match;  // empty pattern
      logic             ovf;           // sticky pattern overflow
   } step_type;

   // Outcome of one text letter from the letter cells.
   typedef struct packed {
      logic match;
      logic found;
   } verdict_type;

endpackage : awm_pkg

`default_nettype wire

FILE: rtl/core/anagram_window_matcher.sv
// Top level of the sliding-window anagram matcher.
//
// Requests come in on req_*: req_tuser holds the kind (clear all, pattern
// letter, text letter, restart text) and req_tdata[4:0] the letter a..z as
// 0..25. Pattern letters build per-letter counts; text letters slide a window
// of pattern length and each accepted text letter yields one response on
// rsp_*: window match, sticky found and sticky pattern overflow. Other kinds,
// and letters outside the alphabet, yield no response.
// A request passes the request queue, the step register and the result register
// before its response shows. One request is taken per cycle for as long as
// responses are taken; the rate is set by the delay-line RAM, written and read
// once per text letter, and the letter cells, updated once per request.
// A four-entry request queue sits between the front and back parts, so when
// rsp_tready is low the held response stays put and up to four more requests
// are still accepted before req_tready drops.
// Reset is synchronous and clears all counts and flags; the delay line holds
// no reset value and its read data is only used for positions written since the last restart.
`default_nettype none

`include "anagram_window_matcher_defines.svh"

module anagram_window_matcher
   import awm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] symbol, [7:5] zero
   input  wire logic [REQ_USER_W-1:0] req_tuser,   // [1:0] request kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata    // [0] window_match, [1] found,
                                                   // [2] pattern_overflow, [7:3] zero
);

   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;

   awm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   awm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A matching window always leaves the found flag set in the same response.
   `AWM_ASSERT_IMPLIES(a_match_sets_found, clock, reset,
      rsp_tvalid && rsp_tdata[0], rsp_tdata[1])

   // A clear request is never dropped by the front part.
   `AWM_ASSERT_NEXT(a_clear_is_queued, clock, reset,
      req_tvalid && req_tready && (req_tuser == KIND_CLEAR), q_valid)

   // The back part only leaves queued work waiting while a response is stalled.
   `AWM_ASSERT_IMPLIES(a_back_stalls_on_rsp, clock, reset,
      q_valid && !q_pop, rsp_tvalid && !rsp_tready)

endmodule : anagram_window_matcher

`default_nettype wire

FILE: rtl/core/awm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module awm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : awm_ram

`default_nettype wire

FILE: rtl/core/awm_front.sv
// Front part: accepts requests, drops stray letters and queues the rest.
`default_nettype none

module awm_front
   import awm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] symbol, [7:5] zero
   input  wire logic [REQ_USER_W-1:0] req_tuser,   // [1:0] request kind
   output logic                       q_valid,
   output entry_type                  q_entry,
   input  wire logic                  q_pop
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   entry_type          incoming;
   logic               keep;
   logic               push;

   // Classify the request: a letter outside the alphabet has no effect at all.
   always_comb begin
      incoming.kind = kind_type'(req_tuser);
      incoming.sym  = req_tdata[SYM_W-1:0];
      keep = (incoming.kind == KIND_CLEAR) || (incoming.kind == KIND_RESTART) ||
             (incoming.sym < SYM_W'(ALPHABET));
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign q_valid    = (count_ff != '0);
   assign q_entry    = slot_ff[rd_ptr_ff];

   // Queue pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule : awm_front

`default_nettype wire

FILE: rtl/core/awm_lanes.sv
// Letter cells: per-letter pattern and window counts with their mismatch bits.
`default_nettype none

module awm_lanes
   import awm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire step_type         step,
   input  wire logic [SYM_W-1:0] old_sym,
   output verdict_type           verdict
);

   logic [LEN_W-1:0]    pat_ff [ALPHABET];
   logic [LEN_W-1:0]    pat_in [ALPHABET];
   logic [LEN_W-1:0]    cnt_ff [ALPHABET];
   logic [LEN_W-1:0]    cnt_in [ALPHABET];
   logic [ALPHABET-1:0] diff_ff, diff_in;
   logic                found_ff, found_in;
   logic [ALPHABET-1:0] inc_v, dec_v;
   logic                old_ok;
   logic                match;

   assign old_ok = step.rem && (old_sym < SYM_W'(ALPHABET));

   // Each cell decides on its own whether it gains or loses a letter.
   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         inc_v[i] = (step.sym == SYM_W'(i));
         dec_v[i] = old_ok && (old_sym == SYM_W'(i)) && (cnt_ff[i] != '0);
      end
   end

   // Next cell state; a differing letter is simply a set mismatch bit.
   always_comb begin
      pat_in   = pat_ff;
      cnt_in   = cnt_ff;
      diff_in  = diff_ff;
      found_in = found_ff;
      match    = 1'b0;
      if (enable) begin
         unique case (step.kind)
            KIND_CLEAR: begin
               for (int i = 0; i < ALPHABET; i++) begin
                  pat_in[i] = '0;
                  cnt_in[i] = '0;
               end
               diff_in  = '0;
               found_in = 1'b0;
            end
            KIND_PATTERN: begin
               for (int i = 0; i < ALPHABET; i++) begin
                  pat_in[i]  = pat_ff[i] + LEN_W'(step.add && inc_v[i]);
                  cnt_in[i]  = '0;
                  diff_in[i] = (pat_in[i] != '0);
               end
               found_in = 1'b0;
            end
            KIND_RESTART: begin
               for (int i = 0; i < ALPHABET; i++) begin
                  cnt_in[i]  = '0;
                  diff_in[i] = (pat_ff[i] != '0);
               end
               found_in = 1'b0;
            end
            KIND_TEXT: begin
               if (step.always_match) begin
                  match    = 1'b1;
                  found_in = 1'b1;
               end else begin
                  for (int i = 0; i < ALPHABET; i++) begin
                     cnt_in[i]  = cnt_ff[i] + LEN_W'(inc_v[i]) - LEN_W'(dec_v[i]);
                     diff_in[i] = (cnt_in[i] != pat_ff[i]);
                  end
                  match    = step.full && (diff_in == '0);
                  found_in = found_ff || match;
               end
            end
            default: begin
               found_in = found_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET; i++) begin
            pat_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         diff_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         pat_ff   <= pat_in;
         cnt_ff   <= cnt_in;
         diff_ff  <= diff_in;
         found_ff <= found_in;
      end
   end

   assign verdict.match = match;
   assign verdict.found = found_in;

endmodule : awm_lanes

`default_nettype wire

FILE: rtl/core/awm_back.sv
// Back part: window sequencing, text delay line, letter cells and result register.
`default_nettype none

module awm_back
   import awm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire entry_type             q_entry,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [POS_W-1:0]      wp_ff, wp_in;
   logic                  ovf_ff, ovf_in;
   step_type              step_ff, step_in;
   logic                  step_valid_ff;
   logic                  ram_wr;
   logic [POS_W-1:0]      ram_rd_addr;
   logic [SYM_W-1:0]      old_sym;
   verdict_type           verdict;
   logic                  advance;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // The whole back part moves whenever the result register can take a value.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign q_pop   = advance && q_valid;

   // Sequencing stage: pattern length, window fill and delay line position.
   always_comb begin
      len_in  = len_ff;
      fill_in = fill_ff;
      wp_in   = wp_ff;
      ovf_in  = ovf_ff;
      step_in.kind         = q_entry.kind;
      step_in.sym          = q_entry.sym;
      step_in.add          = 1'b0;
      step_in.rem          = 1'b0;
      step_in.full         = 1'b0;
      step_in.always_match = 1'b0;
      unique case (q_entry.kind)
         KIND_CLEAR: begin
            len_in  = '0;
            fill_in = '0;
            wp_in   = '0;
            ovf_in  = 1'b0;
         end
         KIND_PATTERN: begin
            if (len_ff >= LEN_W'(MAX_PATTERN)) begin
               ovf_in = 1'b1;
            end else begin
               len_in      = len_ff + LEN_W'(1);
               step_in.add = 1'b1;
            end
            fill_in = '0;
            wp_in   = '0;
         end
         KIND_RESTART: begin
            fill_in = '0;
            wp_in   = '0;
         end
         KIND_TEXT: begin
            if (len_ff == '0) begin
               step_in.always_match = 1'b1;
            end else begin
               if (fill_ff >= len_ff) begin
                  step_in.rem = 1'b1;
               end else begin
                  fill_in = fill_ff + LEN_W'(1);
               end
               wp_in        = wp_ff + POS_W'(1);
               step_in.full = (fill_in == len_ff);
            end
         end
         default: begin
            len_in = len_ff;
         end
      endcase
      step_in.ovf = ovf_in;
   end

   // Text letters enter the delay line; the letter one pattern length back
   // is read in the same cycle and arrives with the step register.
   assign ram_wr      = q_pop && (q_entry.kind == KIND_TEXT) && (len_ff != '0);
   assign ram_rd_addr = wp_ff - len_ff[POS_W-1:0];

   awm_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_PATTERN)
   ) u_delay_line (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wp_ff),
      .wr_data (q_entry.sym),
      .rd_en   (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (old_sym)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         fill_ff       <= '0;
         wp_ff         <= '0;
         ovf_ff        <= 1'b0;
         step_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            len_ff  <= len_in;
            fill_ff <= fill_in;
            wp_ff   <= wp_in;
            ovf_ff  <= ovf_in;
         end
         if (advance) begin
            step_valid_ff <= q_valid;
         end
      end
   end

   // Step payload needs no reset.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         step_ff <= step_in;
      end
   end

   // Count update stage.
   awm_lanes u_lanes (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance && step_valid_ff),
      .step    (step_ff),
      .old_sym (old_sym),
      .verdict (verdict)
   );

   // Result register: only text letters produce a response.
   assign rsp_valid_in = advance ? (step_valid_ff && (step_ff.kind == KIND_TEXT))
                                 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {(RSP_DATA_W - 3)'(0), step_ff.ovf, verdict.found, verdict.match};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : awm_back

`default_nettype wire
